// File: hw/rtl/scpi_pkg.sv
// ----------------------------------------------------------------------------
// scpi_pkg
// Shared constants, register indexes and helpers for the speed clamp and
// pose integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package scpi_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MAX_SPEED     = 3'd0;
    localparam logic [2:0] REG_TIME_STEP     = 3'd1;
    localparam logic [2:0] REG_START_X       = 3'd2;
    localparam logic [2:0] REG_START_Y       = 3'd3;
    localparam logic [2:0] REG_START_HEADING = 3'd4;

    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // reset values
    localparam logic [30:0] MAX_SPEED_RST = 31'd65536;
    localparam logic [15:0] TIME_STEP_RST = 16'd6554;

    localparam int CORDIC_ITER_DEF = 16;
    localparam int CORDIC_ITER_MAX = 24;

    // angle constants, radians Q16 and Q2.13
    localparam logic signed [21:0] PI_Q16   = 22'sd205887;
    localparam logic signed [15:0] HEAD_MAX = 16'sd25736;

    // CORDIC arctangent table, Q16 radians rounded to nearest
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] a;
        begin
            case (i)
                5'd0:    a = 16'd51472;
                5'd1:    a = 16'd30386;
                5'd2:    a = 16'd16055;
                5'd3:    a = 16'd8150;
                5'd4:    a = 16'd4091;
                5'd5:    a = 16'd2047;
                5'd6:    a = 16'd1024;
                5'd7:    a = 16'd512;
                5'd8:    a = 16'd256;
                5'd9:    a = 16'd128;
                5'd10:   a = 16'd64;
                5'd11:   a = 16'd32;
                5'd12:   a = 16'd16;
                5'd13:   a = 16'd8;
                5'd14:   a = 16'd4;
                5'd15:   a = 16'd2;
                5'd16:   a = 16'd1;
                default: a = 16'd0;
            endcase
            return a;
        end
    endfunction

endpackage : scpi_pkg

`default_nettype wire

// File: hw/rtl/scpi_serial_mul.sv
// ----------------------------------------------------------------------------
// scpi_serial_mul
// Unsigned shift-and-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scpi_serial_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [AW-1:0]      a,
    input  wire logic [BW-1:0]      b,
    output logic                    done,
    output logic [AW+BW-1:0]        prod
);

    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg;
    logic [AW+BW-1:0] mcand_reg;
    logic [BW-1:0]    mplier_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // one partial product a cycle, least significant bit first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                acc_reg    <= '0;
                mcand_reg  <= {{BW{1'b0}}, a};
                mplier_reg <= b;
            end
            else if (busy_reg)
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule : scpi_serial_mul

`default_nettype wire

// File: hw/rtl/scpi_serial_div.sv
// ----------------------------------------------------------------------------
// scpi_serial_div
// Restoring unsigned divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scpi_serial_div #(
    parameter int NW = 64,
    parameter int DW = 33
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};

    // shift one dividend bit into the remainder and try the subtract
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, d_reg})
                begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule : scpi_serial_div

`default_nettype wire

// File: hw/rtl/scpi_serial_sqrt.sv
// ----------------------------------------------------------------------------
// scpi_serial_sqrt
// Digit-by-digit integer square root: one root bit (two radicand bits) a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scpi_serial_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] rad,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] v_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] shifted;
    logic [35:0] tst;

    // remainder stays below twice the partial root, so 34 bits hold it
    assign shifted = {rem_reg, v_reg[63:62]};
    assign tst     = {2'b00, root_reg, 2'b01};

    // classic restoring style: floor root, two bits of radicand a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                v_reg    <= rad;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                v_reg <= v_reg << 2;
                if (shifted >= tst)
                begin
                    rem_reg  <= 34'(shifted - tst);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule : scpi_serial_sqrt

`default_nettype wire

// File: hw/rtl/speed_clamp_pose_integrator.sv
// ----------------------------------------------------------------------------
// speed_clamp_pose_integrator
// Clamps a planar velocity request to the speed limit, integrates the pose
// and derives the heading with a CORDIC.
// ----------------------------------------------------------------------------
// Sequence: a request within the limit takes five multiplies, then
//   CORDIC_ITERATIONS CORDIC rotations and a final heading step; when the
//   limit bites it adds a root, two products and two divisions. One request
//   at a time: the next is taken in the cycle after the result leaves.
// Reset: pose loads the start registers at reset values, velocity clears.
`default_nettype none

module speed_clamp_pose_integrator
    import scpi_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [31:0]    cmd_vel_x,
    input  wire logic signed [31:0]    cmd_vel_y,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         out_x,
    output logic signed [31:0]         out_y,
    output logic signed [15:0]         out_heading,
    output logic signed [31:0]         lim_vel_x,
    output logic signed [31:0]         lim_vel_y,
    output logic                       was_limited
);

    localparam int IW = $clog2(CORDIC_ITER_MAX + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQL, ST_CMP, ST_ROOT, ST_MULX, ST_DIVX,
        ST_MULY, ST_DIVY, ST_DTX, ST_DTY, ST_CORD, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration and pose
    logic [30:0]        max_speed_reg;
    logic [15:0]        time_step_reg;
    logic signed [15:0] start_heading_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [15:0] heading_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg;
    logic               limited_reg;

    // working registers
    logic signed [31:0] vx_reg, vy_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        speed_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [23:0] cz_reg;
    logic [IW-1:0]      it_reg;

    // serial units; the multiplier and divider are shared
    logic        mul_start, div_start, sqrt_start;
    logic [31:0] mul_a, mul_b;
    logic        mul_done, div_done, sqrt_done;
    logic [63:0] mul_p, div_q;
    logic [31:0] sqrt_r;
    logic [63:0] div_n;

    logic [31:0] mag_x, mag_y;
    assign mag_x = vx_reg[31] ? 32'(-vx_reg) : 32'(vx_reg);
    assign mag_y = vy_reg[31] ? 32'(-vy_reg) : 32'(vy_reg);

    scpi_serial_mul #(.AW(32), .BW(32)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .prod(mul_p)
    );

    scpi_serial_div #(.NW(64), .DW(32)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_n),
        .den(speed_reg), .done(div_done), .quo(div_q)
    );

    scpi_serial_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start), .rad(sum_reg),
        .done(sqrt_done), .root(sqrt_r)
    );

    // operand selection for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_SQX:  begin mul_a = mag_x; mul_b = mag_x; end
            ST_SQY:  begin mul_a = mag_y; mul_b = mag_y; end
            ST_SQL:  begin mul_a = {1'b0, max_speed_reg};
                           mul_b = {1'b0, max_speed_reg}; end
            ST_MULX: begin mul_a = mag_x; mul_b = {1'b0, max_speed_reg}; end
            ST_MULY: begin mul_a = mag_y; mul_b = {1'b0, max_speed_reg}; end
            ST_DTX:  begin mul_a = vel_x_reg[31] ? 32'(-vel_x_reg) : vel_x_reg;
                           mul_b = {16'd0, time_step_reg}; end
            ST_DTY:  begin mul_a = vel_y_reg[31] ? 32'(-vel_y_reg) : vel_y_reg;
                           mul_b = {16'd0, time_step_reg}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign div_n = mul_p;

    // start pulses: issued in the first cycle of each state
    logic issued_reg;
    logic step_done;
    // a unit finishing ends its state, so the next state issues afresh
    assign step_done  = (state_reg == ST_IDLE) || mul_done || div_done || sqrt_done;
    assign mul_start  = !issued_reg && (state_reg == ST_SQX || state_reg == ST_SQY ||
                        state_reg == ST_SQL || state_reg == ST_MULX ||
                        state_reg == ST_MULY || state_reg == ST_DTX ||
                        state_reg == ST_DTY);
    assign div_start  = !issued_reg && (state_reg == ST_DIVX || state_reg == ST_DIVY);
    assign sqrt_start = !issued_reg && (state_reg == ST_ROOT);

    // rounded step with sign restored: floor((v*dt + 32768) / 65536)
    logic signed [48:0] sprod;
    logic signed [33:0] delta;
    logic signed [32:0] vsel;
    logic signed [31:0] psel;
    logic signed [33:0] psum;
    logic signed [31:0] psat;
    assign vsel  = (state_reg == ST_DTX) ? 33'(vel_x_reg) : 33'(vel_y_reg);
    assign psel  = (state_reg == ST_DTX) ? pos_x_reg : pos_y_reg;
    assign sprod = vsel[32] ? -$signed({1'b0, mul_p[47:0]}) : $signed({1'b0, mul_p[47:0]});
    assign delta = 34'((sprod + 49'sd32768) >>> 16);
    assign psum  = 34'(psel) + delta;
    assign psat  = (psum > 34'sd2147483647)  ? 32'sh7FFFFFFF :
                   (psum < -34'sd2147483648) ? 32'sh80000000 : psum[31:0];

    // CORDIC step
    logic signed [33:0] xs, ys;
    logic [15:0]        ang;
    logic signed [23:0] zr;
    assign xs  = cx_reg >>> it_reg;
    assign ys  = cy_reg >>> it_reg;
    assign ang = atan_q16(5'(it_reg));
    assign zr  = (cz_reg + 24'sd4) >>> 3;

    logic signed [31:0] qx, qy;
    assign qx = vx_reg[31] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
    assign qy = vy_reg[31] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);

    // sequencer, pose and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            issued_reg        <= 1'b0;
            max_speed_reg     <= MAX_SPEED_RST;
            time_step_reg     <= TIME_STEP_RST;
            start_heading_reg <= '0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            heading_reg       <= '0;
            vel_x_reg         <= '0;
            vel_y_reg         <= '0;
            limited_reg       <= 1'b0;
        end
        else
        begin
            issued_reg <= !step_done;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_SPEED:     max_speed_reg <= cfg_data[30:0];
                    REG_TIME_STEP:     time_step_reg <= cfg_data[15:0];
                    REG_START_X:       pos_x_reg     <= cfg_data;
                    REG_START_Y:       pos_y_reg     <= cfg_data;
                    REG_START_HEADING:
                    begin
                        start_heading_reg <= cfg_data[15:0];
                        heading_reg       <= cfg_data[15:0];
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        vx_reg    <= cmd_vel_x;
                        vy_reg    <= cmd_vel_y;
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX:
                    if (mul_done)
                    begin
                        sum_reg   <= mul_p;
                        state_reg <= ST_SQY;
                    end
                ST_SQY:
                    if (mul_done)
                    begin
                        sum_reg   <= sum_reg + mul_p;
                        state_reg <= ST_SQL;
                    end
                ST_SQL:
                    if (mul_done)
                    begin
                        if (sum_reg > mul_p)
                        begin
                            limited_reg <= 1'b1;
                            state_reg   <= ST_ROOT;
                        end
                        else
                        begin
                            limited_reg <= 1'b0;
                            vel_x_reg   <= vx_reg;
                            vel_y_reg   <= vy_reg;
                            state_reg   <= ST_DTX;
                        end
                    end
                ST_ROOT:
                    if (sqrt_done)
                    begin
                        speed_reg <= sqrt_r;
                        state_reg <= ST_MULX;
                    end
                ST_MULX:
                    if (mul_done)
                        state_reg <= ST_DIVX;
                ST_DIVX:
                    if (div_done)
                    begin
                        vel_x_reg <= qx;
                        state_reg <= ST_MULY;
                    end
                ST_MULY:
                    if (mul_done)
                        state_reg <= ST_DIVY;
                ST_DIVY:
                    if (div_done)
                    begin
                        vel_y_reg <= qy;
                        state_reg <= ST_DTX;
                    end
                ST_DTX:
                    if (mul_done)
                    begin
                        pos_x_reg <= psat;
                        state_reg <= ST_DTY;
                    end
                ST_DTY:
                    if (mul_done)
                    begin
                        pos_y_reg <= psat;
                        it_reg    <= '0;
                        // quadrant fold for the vectoring CORDIC
                        if (vel_x_reg[31])
                        begin
                            cx_reg <= -34'(vel_x_reg);
                            cy_reg <= -34'(vel_y_reg);
                            cz_reg <= vel_y_reg[31] ? -24'(PI_Q16) : 24'(PI_Q16);
                        end
                        else
                        begin
                            cx_reg <= 34'(vel_x_reg);
                            cy_reg <= 34'(vel_y_reg);
                            cz_reg <= '0;
                        end
                        state_reg <= ST_CORD;
                    end
                ST_CORD:
                begin
                    if (it_reg == IW'(CORDIC_ITERATIONS))
                    begin
                        if (vel_x_reg == 32'sd0 && vel_y_reg == 32'sd0)
                            heading_reg <= '0;
                        else if (zr > 24'(HEAD_MAX))
                            heading_reg <= HEAD_MAX;
                        else if (zr < -24'(HEAD_MAX))
                            heading_reg <= -HEAD_MAX;
                        else
                            heading_reg <= zr[15:0];
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        if (cy_reg > 0)
                        begin
                            cx_reg <= cx_reg + ys;
                            cy_reg <= cy_reg - xs;
                            cz_reg <= cz_reg + 24'(ang);
                        end
                        else
                        begin
                            cx_reg <= cx_reg - ys;
                            cy_reg <= cy_reg + xs;
                            cz_reg <= cz_reg - 24'(ang);
                        end
                        it_reg <= it_reg + 1'b1;
                    end
                end
                ST_OUT:
                    if (out_ready)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign out_x       = pos_x_reg;
    assign out_y       = pos_y_reg;
    assign out_heading = heading_reg;
    assign lim_vel_x   = vel_x_reg;
    assign lim_vel_y   = vel_y_reg;
    assign was_limited = limited_reg;

    // checks
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_heading <= HEAD_MAX || start_heading_reg > HEAD_MAX))
        else $error("heading out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule : speed_clamp_pose_integrator

`default_nettype wire

// File: tb/sv/speed_clamp_pose_checker.sv
// ----------------------------------------------------------------------------
// speed_clamp_pose_checker
// Watches the configuration port and the request and result channels of
// the speed clamp and pose integrator. It keeps its own pose, velocity and
// register copies, works out the expected pose for each accepted request,
// and compares each returned pose field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_clamp_pose_checker
    import scpi_pkg::*;
#(
    parameter int STEPS = CORDIC_ITER_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic signed [31:0]    cmd_vel_x,
    input  wire logic signed [31:0]    cmd_vel_y,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic signed [31:0]    out_x,
    input  wire logic signed [31:0]    out_y,
    input  wire logic signed [15:0]    out_heading,
    input  wire logic signed [31:0]    lim_vel_x,
    input  wire logic signed [31:0]    lim_vel_y,
    input  wire logic                  was_limited,
    output int                         fail_count,
    output int                         pending
);

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] hd;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               limited;
    } pose_t;

    pose_t pose_queue[$];

    // register and pose copies
    logic [30:0]        speed_limit;
    logic [15:0]        dt;
    logic signed [31:0] cur_x, cur_y, cur_vx, cur_vy;
    logic signed [15:0] cur_hd;

    localparam longint PI_RAD = 205887;
    localparam longint HD_LIM = 25736;

    function automatic longint angle_step(input int i);
        case (i)
            0: return 51472;   1: return 30386;  2: return 16055;  3: return 8150;
            4: return 4091;    5: return 2047;   6: return 1024;   7: return 512;
            8: return 256;     9: return 128;    10: return 64;    11: return 32;
            12: return 16;     13: return 8;     14: return 4;     15: return 2;
            16: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b, rem;
        r = 0;
        rem = v;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_comp(input longint v, input longint lim,
                                                      input longint spd);
        longint mag, q;
        mag = (v < 0) ? -v : v;
        q = (mag * lim) / spd;
        return 32'((v < 0) ? -q : q);
    endfunction

    function automatic logic signed [31:0] move(input logic signed [31:0] p,
                                                input logic signed [31:0] v,
                                                input logic [15:0] step);
        longint prod, s;
        prod = longint'(v) * longint'({1'b0, step});
        s = longint'(p) + ((prod + 32768) >>> 16);
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return 32'(s);
    endfunction

    function automatic logic signed [15:0] bearing(input longint vy, input longint vx);
        longint cx, cy, cz, nx, ny;
        if (vx == 0 && vy == 0)
            return 0;
        cx = vx;
        cy = vy;
        cz = 0;
        // left half plane: rotate by pi first
        if (cx < 0)
        begin
            cz = (cy >= 0) ? PI_RAD : -PI_RAD;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < STEPS && i < 25; i++)
        begin
            if (cy > 0)
            begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                cz = cz + angle_step(i);
            end
            else
            begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                cz = cz - angle_step(i);
            end
            cx = nx;
            cy = ny;
        end
        cz = (cz + 4) >>> 3;
        if (cz > HD_LIM)
            cz = HD_LIM;
        if (cz < -HD_LIM)
            cz = -HD_LIM;
        return 16'(cz);
    endfunction

    // one request moves the kept pose on and yields the expected result
    task automatic integrate(input logic signed [31:0] cx, input logic signed [31:0] cy);
        longint vx, vy, lim;
        logic [63:0] sum, spd;
        pose_t e;
        vx = longint'(cx);
        vy = longint'(cy);
        lim = {33'd0, speed_limit};
        sum = vx * vx + vy * vy;
        e.limited = sum > lim * lim;
        if (e.limited)
        begin
            spd = root64(sum);
            cur_vx = clamp_comp(vx, lim, spd);
            cur_vy = clamp_comp(vy, lim, spd);
        end
        else
        begin
            cur_vx = cx;
            cur_vy = cy;
        end
        cur_x = move(cur_x, cur_vx, dt);
        cur_y = move(cur_y, cur_vy, dt);
        cur_hd = bearing(longint'(cur_vy), longint'(cur_vx));
        e.px = cur_x;
        e.py = cur_y;
        e.hd = cur_hd;
        e.vx = cur_vx;
        e.vy = cur_vy;
        pose_queue.insert(pose_queue.size(), e);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pose_t e;
        if (!rst_n)
        begin
            speed_limit = MAX_SPEED_RST;
            dt = TIME_STEP_RST;
            cur_x = 0;
            cur_y = 0;
            cur_hd = 0;
            cur_vx = 0;
            cur_vy = 0;
            pose_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_SPEED:     speed_limit = cfg_data[30:0];
                    REG_TIME_STEP:     dt = cfg_data[15:0];
                    REG_START_X:       cur_x = cfg_data;
                    REG_START_Y:       cur_y = cfg_data;
                    REG_START_HEADING: cur_hd = cfg_data[15:0];
                    default: ;
                endcase
            end
            // result side first: it frees the slot the next request may take
            if (out_valid && out_ready)
            begin
                if (pose_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = pose_queue.pop_front();
                    check_field("out_x", longint'(e.px), longint'(out_x));
                    check_field("out_y", longint'(e.py), longint'(out_y));
                    check_field("out_heading", longint'(e.hd), longint'(out_heading));
                    check_field("lim_vel_x", longint'(e.vx), longint'(lim_vel_x));
                    check_field("lim_vel_y", longint'(e.vy), longint'(lim_vel_y));
                    check_field("was_limited", longint'(e.limited), longint'(was_limited));
                end
            end
            if (in_valid && in_ready)
                integrate(cmd_vel_x, cmd_vel_y);
        end
        pending = pose_queue.size();
    end

endmodule : speed_clamp_pose_checker

`default_nettype wire

// File: tb/sv/speed_clamp_pose_integrator_test.sv
// ----------------------------------------------------------------------------
// speed_clamp_pose_integrator_test
// Drives velocity requests and register settings into the speed clamp and
// pose integrator: a directed run over the corner cases, then phases of
// random requests under varied limits, steps and start poses, with random
// gaps on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_clamp_pose_integrator_test;
    import scpi_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int SETTLE   = 400;
    localparam int HOLD_LEN = 3000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [31:0]    cmd_vel_x;
    logic signed [31:0]    cmd_vel_y;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [31:0]    out_x;
    logic signed [31:0]    out_y;
    logic signed [15:0]    out_heading;
    logic signed [31:0]    lim_vel_x;
    logic signed [31:0]    lim_vel_y;
    logic                  was_limited;
    int                    fail_count;
    int                    pending;
    logic                  hold_req;
    int                    idle_cycles;

    speed_clamp_pose_integrator dut (.*);

    speed_clamp_pose_checker chk (.*);

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: cycles with no handshake on either channel
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        bit held;
        gap = 0;
        held = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                out_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                held = 1'b1;
            end
            if (gap > 0)
            begin
                out_ready = 1'b0;
                gap--;
            end
            else
            begin
                out_ready = 1'b1;
                if ($urandom_range(0, 9) == 0)
                    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150)
                                                      : $urandom_range(1, 4);
            end
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // stop offering, wait for every result, then let the block settle
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // present one request and hold it until taken
    task automatic send_vel(input logic signed [31:0] vx, input logic signed [31:0] vy);
        in_valid = 1'b1;
        cmd_vel_x = vx;
        cmd_vel_y = vy;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int n;
        n = 0;
        if ($urandom_range(0, 3) == 0)
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3);
        if (n > 0)
        begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_vel();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return 0;
            3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            4, 5: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return MAX_SPEED_RST;
            2: return 32'h7fffffff;
            3: return $urandom;
            default: return $urandom_range(1, 1 << 22);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 16'hffff;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 4))
            0: return 32'h7fffff00;
            1: return 32'h80000100;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd_vel_x = '0;
        cmd_vel_y = '0;
        hold_req = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        // directed: reset settings
        send_vel(0, 0);
        send_vel(32'sh00008000, 0);
        send_vel(32'sh00010000, 0);
        send_vel(0, 32'sh00010000);
        send_vel(32'sh7fffffff, 0);
        send_vel(32'sh80000000, 0);
        send_vel(0, 32'sh80000000);
        send_vel(32'sh80000000, 32'sh80000000);
        send_vel(32'sh7fffffff, 32'sh7fffffff);
        send_vel(-32'sh00008000, 0);
        send_vel(-32'sh00008000, -32'sh00000010);
        send_vel(-1, 1);
        send_vel(32'sh0000b505, -32'sh0000b505);
        drain();

        // directed: zero limit, zero step, start pose near saturation
        reg_write(REG_MAX_SPEED, 0);
        reg_write(REG_TIME_STEP, 0);
        reg_write(REG_START_X, 32'h7ffffff0);
        reg_write(REG_START_Y, 32'h80000010);
        reg_write(REG_START_HEADING, 16'h6488);
        reg_write(3'd5, 32'hffffffff);
        send_vel(32'sh00001000, 32'sh00002000);
        send_vel(0, 0);
        drain();
        reg_write(REG_MAX_SPEED, 32'hffffffff);
        reg_write(REG_TIME_STEP, 16'hffff);
        send_vel(32'sh7fffffff, 32'sh80000000);
        send_vel(32'sh7fffffff, 32'sh80000000);
        send_vel(32'sh80000000, 32'sh7fffffff);
        send_vel(32'sh80000000, 32'sh7fffffff);
        drain();

        // random phases, new settings each time
        for (int ph = 0; ph < 8; ph++)
        begin
            reg_write(REG_MAX_SPEED, pick_limit());
            reg_write(REG_TIME_STEP, pick_step());
            reg_write(REG_START_X, pick_start());
            reg_write(REG_START_Y, pick_start());
            reg_write(REG_START_HEADING, $urandom_range(0, 51472) - 25736);
            if ($urandom_range(0, 2) == 0)
                reg_write(3'($urandom_range(5, 7)), $urandom);
            if (ph == 2)
                hold_req = 1'b1;
            for (int k = 0; k < 48; k++)
            begin
                if (ph != 2)
                    sender_gap();
                send_vel(pick_vel(), pick_vel());
            end
            in_valid = 1'b0;
            drain();
        end

        in_valid = 1'b0;
        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule : speed_clamp_pose_integrator_test

`default_nettype wire
